>>> hdl/wfpa_pkg.sv
`default_nettype none
package wfpa_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int ACNT_W     = $clog2(NUM_BLOCKS + 1);
	localparam int CFG_W      = 5;
	localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(16);

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_ALLOC = 1'b1
	} func_t;

	typedef struct packed {
		logic        func;
		logic [3:0]  block_index;
		logic [15:0] size;
	} in_item_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_block;
		logic [15:0] block_left;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_we;   // store the input item's size
		logic start;     // latch request, reset search
		logic issue;     // read entry at scan pointer, advance
		logic commit;    // write back winner, load output register
	} dp_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic count_zero;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/wfpa_ctrl.sv
`default_nettype none
module wfpa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                in_func,
	input  wire wfpa_pkg::dp_stat_t  stat,
	output wfpa_pkg::dp_cmd_t        cmd
);

	wfpa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wfpa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == wfpa_pkg::FUNC_ALLOC) begin
						cmd.start = 1'b1;
						state_d   = stat.count_zero ? wfpa_pkg::ST_FINISH : wfpa_pkg::ST_SCAN;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			wfpa_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = wfpa_pkg::ST_DRAIN;
				end
			end
			wfpa_pkg::ST_DRAIN: begin
				// last read data is compared here
				state_d = wfpa_pkg::ST_FINISH;
			end
			wfpa_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = wfpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wfpa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/wfpa_dp.sv
`default_nettype none
module wfpa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wfpa_pkg::in_item_t            in_data,
	input  wire logic                          cfg_we,
	input  wire logic [wfpa_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output wfpa_pkg::out_item_t                out_data,
	input  wire wfpa_pkg::dp_cmd_t             cmd,
	output wfpa_pkg::dp_stat_t                 stat
);

	localparam int IW = wfpa_pkg::IDX_W;
	localparam int AW = wfpa_pkg::ACNT_W;
	localparam int SW = wfpa_pkg::SIZE_BITS;

	logic [SW-1:0]  mem [wfpa_pkg::NUM_BLOCKS];

	logic [wfpa_pkg::CFG_W-1:0] block_count_q;
	logic [AW-1:0]  active_cnt;
	logic [IW-1:0]  ptr_q;
	logic [SW-1:0]  req_q;
	logic [SW-1:0]  rd_data_s1;
	logic [IW-1:0]  rd_idx_s1;
	logic           rd_vld_s1;
	logic           found_q;
	logic [IW-1:0]  best_idx_q;
	logic [SW-1:0]  best_val_q;
	logic           out_valid_q;
	wfpa_pkg::out_item_t out_q;

	logic [SW-1:0]  in_size;
	logic [SW-1:0]  left;
	logic           load_ok;
	logic           better;

	assign in_size = SW'(in_data.size);
	assign left    = best_val_q - req_q;
	assign load_ok = 32'(in_data.block_index) < 32'(wfpa_pkg::NUM_BLOCKS);

	// counts above the table size are clamped
	always_comb begin
		if (32'(block_count_q) > 32'(wfpa_pkg::NUM_BLOCKS)) begin
			active_cnt = AW'(wfpa_pkg::NUM_BLOCKS);
		end else begin
			active_cnt = AW'(block_count_q);
		end
	end

	assign stat.count_zero = (active_cnt == '0);
	assign stat.last_issue = ((AW'(ptr_q) + AW'(1)) == active_cnt);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign better = rd_vld_s1 && (rd_data_s1 >= req_q) && (!found_q || rd_data_s1 > best_val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= wfpa_pkg::BLOCK_COUNT_RST;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_wdata;
			end
			rd_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= in_size;
			ptr_q <= '0;
		end else if (cmd.issue) begin
			ptr_q <= ptr_q + IW'(1);
		end
		rd_idx_s1 <= ptr_q;
		if (better) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_data_s1;
		end
		if (cmd.commit) begin
			out_q.granted      <= found_q;
			out_q.chosen_block <= found_q ? 4'(best_idx_q) : 4'd0;
			out_q.block_left   <= found_q ? 16'(left) : 16'd0;
		end
	end

	// single write port: load transfer or winner write-back
	always_ff @(posedge clk) begin
		if (cmd.load_we && load_ok) begin
			mem[IW'(in_data.block_index)] <= in_size;
		end else if (cmd.commit && found_q) begin
			mem[best_idx_q] <= left;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[ptr_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

>>> hdl/worst_fit_partition_allocator.sv
// Load transfer: stores the size, no result. Allocate: N = min(block_count, 16).
// N >= 1: the result and the next item are bound by the one-entry-per-cycle scan of the
// free-size memory; N = 0 skips the scan.
// A result still held in the output register delays the next result and the next item.
// Reset (arst_n low, asynchronous) idles the controller, empties the output register and sets
// block_count to 16; free sizes are undefined until loaded.
`default_nettype none
module worst_fit_partition_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire wfpa_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output wfpa_pkg::out_item_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic [wfpa_pkg::CFG_W-1:0]    cfg_wdata
);

	wfpa_pkg::dp_cmd_t  cmd;
	wfpa_pkg::dp_stat_t stat;

	wfpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_func  (in_data.func),
		.stat     (stat),
		.cmd      (cmd)
	);

	wfpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;

	localparam int CLK_HALF      = 5;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_SHOWN     = 10;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 140;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	wfpa_pkg::in_item_t           in_data   = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	wfpa_pkg::out_item_t          out_data;
	logic                         cfg_we    = 1'b0;
	logic [wfpa_pkg::CFG_W-1:0]   cfg_wdata = '0;

	// Mirror of the partition table and the count register
	logic [15:0]                  free_sz [wfpa_pkg::NUM_BLOCKS] = '{default: '0};
	logic [wfpa_pkg::CFG_W-1:0]   count_reg = wfpa_pkg::BLOCK_COUNT_RST;
	wfpa_pkg::out_item_t          pending_grants [$];
	int                           mismatches  = 0;
	bit                           tx_gaps     = 1'b0;
	bit                           rx_stalls   = 1'b0;
	int                           rx_hold_req = 0;

	worst_fit_partition_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int unsigned active_count();
		return (count_reg > wfpa_pkg::NUM_BLOCKS) ? wfpa_pkg::NUM_BLOCKS : count_reg;
	endfunction

	// Mostly short gaps, now and then a long one; never zero
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one accepted item to the table; an allocate queues its grant
	function automatic void update_partitions(input wfpa_pkg::in_item_t it);
		int unsigned         n;
		int unsigned         best;
		bit                  hit;
		wfpa_pkg::out_item_t res;
		if (wfpa_pkg::func_t'(it.func) == wfpa_pkg::FUNC_LOAD) begin
			free_sz[it.block_index] = it.size;
			return;
		end
		n    = active_count();
		hit  = 1'b0;
		best = 0;
		for (int j = 0; j < n; j++) begin
			if (free_sz[j] >= it.size && (!hit || free_sz[j] > free_sz[best])) begin
				best = j;
				hit  = 1'b1;
			end
		end
		res = '0;
		if (hit) begin
			free_sz[best]    = free_sz[best] - it.size;
			res.granted      = 1'b1;
			res.chosen_block = best[3:0];
			res.block_left   = free_sz[best];
		end
		pending_grants.push_back(res);
	endfunction

	function automatic wfpa_pkg::in_item_t load_item(input logic [3:0] idx,
		input logic [15:0] sz);
		wfpa_pkg::in_item_t it;
		it.func        = wfpa_pkg::FUNC_LOAD;
		it.block_index = idx;
		it.size        = sz;
		return it;
	endfunction

	function automatic wfpa_pkg::in_item_t alloc_item(input logic [15:0] sz);
		wfpa_pkg::in_item_t it;
		it.func        = wfpa_pkg::FUNC_ALLOC;
		it.block_index = 4'($urandom);
		it.size        = sz;
		return it;
	endfunction

	// Requests are drawn around live entries so that most of them get a grant
	function automatic wfpa_pkg::in_item_t random_item();
		wfpa_pkg::in_item_t it;
		int unsigned        n;
		logic [15:0]        base;
		it.block_index = 4'($urandom);
		it.size        = 16'($urandom);
		n              = active_count();
		base           = (n > 0) ? free_sz[$urandom_range(0, n - 1)] : '0;
		if ($urandom_range(0, 99) < 30) begin
			it.func = wfpa_pkg::FUNC_LOAD;
			case ($urandom_range(0, 5))
				0: it.size = '1;
				1: it.size = '0;
				2: it.size = base;    // tie with a live entry
				3: it.size = 16'($urandom_range(0, 255));
				default: ;
			endcase
		end else begin
			it.func = wfpa_pkg::FUNC_ALLOC;
			case ($urandom_range(0, 9))
				0: it.size = '0;
				1: ;
				2: it.size = base;    // exact fit
				3: it.size = base + 16'd1;
				default: it.size = 16'($urandom_range(0, base));
			endcase
		end
		return it;
	endfunction

	task automatic send_item(input wfpa_pkg::in_item_t it);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		update_partitions(it);
	endtask

	// Stop offering items, wait for every grant, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_block_count(input logic [wfpa_pkg::CFG_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = v;
	endtask

	task automatic note_error(input string what, input wfpa_pkg::out_item_t e,
		input wfpa_pkg::out_item_t a);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t %s: expected granted=%0d block=%0d left=%0d, got granted=%0d block=%0d left=%0d",
				$realtime, what, e.granted, e.chosen_block, e.block_left,
				a.granted, a.chosen_block, a.block_left);
	endtask

	// Ties, exact fits, zero and oversized requests on a fully loaded table
	task automatic test_directed_allocations();
		send_item(load_item(4'd0, 16'd100));
		send_item(load_item(4'd1, 16'hFFFF));
		send_item(load_item(4'd2, 16'd0));
		send_item(load_item(4'd3, 16'hFFFF));
		for (int i = 4; i < wfpa_pkg::NUM_BLOCKS; i++)
			send_item(load_item(4'(i), 16'(1000 + i)));
		send_item(alloc_item(16'hFFFF));
		send_item(alloc_item(16'hFFFF));
		send_item(alloc_item(16'd0));
		send_item(alloc_item(16'hFFFF));
		send_item(alloc_item(16'd1015));
	endtask

	task automatic test_count_extremes();
		set_block_count(5'd0);
		send_item(alloc_item(16'd0));
		send_item(alloc_item(16'd1));
		set_block_count(5'd1);
		send_item(alloc_item(16'd0));
		// stored even though outside the active range
		send_item(load_item(4'd5, 16'hFFFF));
		send_item(alloc_item(16'd1));
		set_block_count(5'd31);
		send_item(alloc_item(16'h8000));
		set_block_count(5'd16);
	endtask

	task automatic test_random_traffic();
		logic [wfpa_pkg::CFG_W-1:0] v;
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: v = 5'd0;
				1: v = 5'd31;
				2, 3: v = 5'($urandom_range(17, 30));
				4, 5: v = 5'd16;
				default: v = 5'($urandom_range(1, 16));
			endcase
			if (p == 0)
				v = 5'd16;
			set_block_count(v);
			tx_gaps   = (p % 4) != 1;
			rx_stalls = (p % 4) != 2;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item());
		end
	endtask

	// Receiver holds off long enough for the block to back up into its input
	task automatic test_output_stall();
		set_block_count(5'd16);
		tx_gaps     = 1'b0;
		rx_hold_req = 300;
		for (int i = 0; i < 40; i++)
			send_item(random_item());
		drain_results();
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin : rx_ready
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
			end else begin
				n = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		wfpa_pkg::out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				note_error("unexpected result", '0, out_data);
			end else begin
				e = pending_grants.pop_front();
				if (out_data.granted !== e.granted)
					note_error("granted mismatch", e, out_data);
				else if (out_data.chosen_block !== e.chosen_block)
					note_error("chosen_block mismatch", e, out_data);
				else if (out_data.block_left !== e.block_left)
					note_error("block_left mismatch", e, out_data);
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_allocations();
		test_count_extremes();
		test_random_traffic();
		test_output_stall();
		drain_results();
		if (mismatches == 0 && pending_grants.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
